// File: design/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared types, codes and constants of the JSON scalar validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

	localparam int unsigned CLASS_QUEUE_DEPTH  = 4;
	localparam int unsigned RESULT_QUEUE_DEPTH = 2;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned CLASS_W  = 5;
	localparam int unsigned POS_W    = 2;
	localparam int unsigned RESULT_W = STATUS_W + KIND_W;

	typedef enum logic [CLASS_W-1:0] {
		CL_END,
		CL_SPACE,
		CL_ZERO,
		CL_DIGIT,
		CL_MINUS,
		CL_PLUS,
		CL_DOT,
		CL_LOW_E,
		CL_UP_E,
		CL_LOW_N,
		CL_LOW_F,
		CL_LOW_T,
		CL_LOW_A,
		CL_LOW_L,
		CL_LOW_S,
		CL_LOW_R,
		CL_LOW_U,
		CL_OTHER
	} class_t;

	typedef enum logic [3:0] {
		PH_LEAD,
		PH_LITERAL,
		PH_SIGN,
		PH_INT_ZERO,
		PH_INT_DIGS,
		PH_FRAC_BEG,
		PH_FRAC_DIGS,
		PH_EXP_BEG,
		PH_EXP_SIGN,
		PH_EXP_DIGS,
		PH_TRAIL,
		PH_ERROR
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_EXPECT,
		ST_INVALID,
		ST_NOT_SINGLE
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NULL,
		KIND_FALSE,
		KIND_TRUE,
		KIND_NUMBER
	} kind_t;

	// expected class of a literal letter after the first; end class never matches
	function automatic class_t tail_class(input kind_t kind, input logic [POS_W-1:0] pos);
		class_t c;
		c = CL_END;
		case (kind)
			KIND_NULL: begin
				case (pos)
					2'd0:    c = CL_LOW_U;
					2'd1:    c = CL_LOW_L;
					2'd2:    c = CL_LOW_L;
					default: c = CL_END;
				endcase
			end
			KIND_FALSE: begin
				case (pos)
					2'd0:    c = CL_LOW_A;
					2'd1:    c = CL_LOW_L;
					2'd2:    c = CL_LOW_S;
					default: c = CL_LOW_E;
				endcase
			end
			KIND_TRUE: begin
				case (pos)
					2'd0:    c = CL_LOW_R;
					2'd1:    c = CL_LOW_U;
					2'd2:    c = CL_LOW_E;
					default: c = CL_END;
				endcase
			end
			default: c = CL_END;
		endcase
		return c;
	endfunction

	// position of the last letter of a literal
	function automatic logic [POS_W-1:0] tail_last(input kind_t kind);
		logic [POS_W-1:0] p;
		case (kind)
			KIND_FALSE: p = 2'd3;
			default:    p = 2'd2;
		endcase
		return p;
	endfunction

endpackage

// File: design/jsv_fifo.sv
// ----------------------------------------------------------------------------
// jsv_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module jsv_fifo #(
	parameter int unsigned WIDTH = jsv_pkg::RESULT_W,
	parameter int unsigned DEPTH = jsv_pkg::RESULT_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/jsv_front.sv
// ----------------------------------------------------------------------------
// jsv_front
// Takes text bytes, sorts each into a character class and queues the classes.
// ----------------------------------------------------------------------------
module jsv_front #(
	parameter int unsigned QDEPTH = jsv_pkg::CLASS_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [jsv_pkg::BYTE_W-1:0]  text_byte,
	output logic                        cls_valid,
	output jsv_pkg::class_t             cls,
	input  logic                        cls_take
);

	jsv_pkg::class_t                  in_cls;
	logic [jsv_pkg::CLASS_W-1:0]      q_data;
	logic                             q_empty;

	always_comb begin
		case (text_byte)
			8'h00:                         in_cls = jsv_pkg::CL_END;
			8'h20, 8'h09, 8'h0A, 8'h0D:    in_cls = jsv_pkg::CL_SPACE;
			"0":                           in_cls = jsv_pkg::CL_ZERO;
			"1", "2", "3", "4", "5",
			"6", "7", "8", "9":            in_cls = jsv_pkg::CL_DIGIT;
			"-":                           in_cls = jsv_pkg::CL_MINUS;
			"+":                           in_cls = jsv_pkg::CL_PLUS;
			".":                           in_cls = jsv_pkg::CL_DOT;
			"e":                           in_cls = jsv_pkg::CL_LOW_E;
			"E":                           in_cls = jsv_pkg::CL_UP_E;
			"n":                           in_cls = jsv_pkg::CL_LOW_N;
			"f":                           in_cls = jsv_pkg::CL_LOW_F;
			"t":                           in_cls = jsv_pkg::CL_LOW_T;
			"a":                           in_cls = jsv_pkg::CL_LOW_A;
			"l":                           in_cls = jsv_pkg::CL_LOW_L;
			"s":                           in_cls = jsv_pkg::CL_LOW_S;
			"r":                           in_cls = jsv_pkg::CL_LOW_R;
			"u":                           in_cls = jsv_pkg::CL_LOW_U;
			default:                       in_cls = jsv_pkg::CL_OTHER;
		endcase
	end

	jsv_fifo #(
		.WIDTH (jsv_pkg::CLASS_W),
		.DEPTH (QDEPTH)
	) u_class_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_cls),
		.full    (full),
		.rd_en   (cls_take),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	assign cls_valid = !q_empty;
	assign cls       = jsv_pkg::class_t'(q_data);

endmodule

// File: design/jsv_back.sv
// ----------------------------------------------------------------------------
// jsv_back
// Grammar state machine over character classes; queues one result per text.
// ----------------------------------------------------------------------------
module jsv_back #(
	parameter int unsigned RDEPTH = jsv_pkg::RESULT_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cls_valid,
	input  jsv_pkg::class_t               cls,
	output logic                          cls_take,
	output logic                          empty,
	input  logic                          pop,
	output logic [jsv_pkg::STATUS_W-1:0]  parse_status,
	output logic [jsv_pkg::KIND_W-1:0]    value_kind
);

	jsv_pkg::phase_t                phase_q, phase_d;
	jsv_pkg::kind_t                 kind_q, kind_d;
	logic [jsv_pkg::POS_W-1:0]      pos_q, pos_d;
	jsv_pkg::status_t               err_q, err_d;

	logic                           res_full;
	logic                           res_push;
	jsv_pkg::status_t               res_status;
	jsv_pkg::kind_t                 res_kind;
	logic [jsv_pkg::RESULT_W-1:0]   res_rd;
	logic                           is_digit;
	logic                           is_exp;

	assign cls_take = cls_valid && (cls != jsv_pkg::CL_END || !res_full);
	assign is_digit = (cls == jsv_pkg::CL_ZERO) || (cls == jsv_pkg::CL_DIGIT);
	assign is_exp   = (cls == jsv_pkg::CL_LOW_E) || (cls == jsv_pkg::CL_UP_E);

	// next state
	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		pos_d   = pos_q;
		err_d   = err_q;
		if (cls == jsv_pkg::CL_END) begin
			phase_d = jsv_pkg::PH_LEAD;
			kind_d  = jsv_pkg::KIND_NULL;
			pos_d   = '0;
			err_d   = jsv_pkg::ST_OK;
		end else begin
			case (phase_q)
				jsv_pkg::PH_LEAD: begin
					case (cls)
						jsv_pkg::CL_SPACE: ;
						jsv_pkg::CL_LOW_N: begin
							kind_d  = jsv_pkg::KIND_NULL;
							pos_d   = '0;
							phase_d = jsv_pkg::PH_LITERAL;
						end
						jsv_pkg::CL_LOW_F: begin
							kind_d  = jsv_pkg::KIND_FALSE;
							pos_d   = '0;
							phase_d = jsv_pkg::PH_LITERAL;
						end
						jsv_pkg::CL_LOW_T: begin
							kind_d  = jsv_pkg::KIND_TRUE;
							pos_d   = '0;
							phase_d = jsv_pkg::PH_LITERAL;
						end
						jsv_pkg::CL_MINUS: begin
							kind_d  = jsv_pkg::KIND_NUMBER;
							phase_d = jsv_pkg::PH_SIGN;
						end
						jsv_pkg::CL_ZERO: begin
							kind_d  = jsv_pkg::KIND_NUMBER;
							phase_d = jsv_pkg::PH_INT_ZERO;
						end
						jsv_pkg::CL_DIGIT: begin
							kind_d  = jsv_pkg::KIND_NUMBER;
							phase_d = jsv_pkg::PH_INT_DIGS;
						end
						default: begin
							kind_d  = jsv_pkg::KIND_NUMBER;
							phase_d = jsv_pkg::PH_ERROR;
							err_d   = jsv_pkg::ST_INVALID;
						end
					endcase
				end
				jsv_pkg::PH_LITERAL: begin
					if (kind_q == jsv_pkg::KIND_NUMBER
							|| cls != jsv_pkg::tail_class(kind_q, pos_q)) begin
						phase_d = jsv_pkg::PH_ERROR;
						err_d   = jsv_pkg::ST_INVALID;
					end else begin
						pos_d = pos_q + 1'b1;
						if (pos_q == jsv_pkg::tail_last(kind_q)) begin
							phase_d = jsv_pkg::PH_TRAIL;
						end
					end
				end
				jsv_pkg::PH_SIGN: begin
					if (cls == jsv_pkg::CL_ZERO) begin
						phase_d = jsv_pkg::PH_INT_ZERO;
					end else if (cls == jsv_pkg::CL_DIGIT) begin
						phase_d = jsv_pkg::PH_INT_DIGS;
					end else begin
						phase_d = jsv_pkg::PH_ERROR;
						err_d   = jsv_pkg::ST_INVALID;
					end
				end
				jsv_pkg::PH_INT_ZERO, jsv_pkg::PH_INT_DIGS, jsv_pkg::PH_FRAC_DIGS: begin
					if (is_digit && phase_q != jsv_pkg::PH_INT_ZERO) begin
						phase_d = phase_q;
					end else if (cls == jsv_pkg::CL_DOT
							&& phase_q != jsv_pkg::PH_FRAC_DIGS) begin
						phase_d = jsv_pkg::PH_FRAC_BEG;
					end else if (is_exp) begin
						phase_d = jsv_pkg::PH_EXP_BEG;
					end else if (cls == jsv_pkg::CL_SPACE) begin
						phase_d = jsv_pkg::PH_TRAIL;
					end else begin
						phase_d = jsv_pkg::PH_ERROR;
						err_d   = jsv_pkg::ST_NOT_SINGLE;
					end
				end
				jsv_pkg::PH_FRAC_BEG, jsv_pkg::PH_EXP_SIGN: begin
					if (is_digit) begin
						phase_d = (phase_q == jsv_pkg::PH_FRAC_BEG) ?
							jsv_pkg::PH_FRAC_DIGS : jsv_pkg::PH_EXP_DIGS;
					end else begin
						phase_d = jsv_pkg::PH_ERROR;
						err_d   = jsv_pkg::ST_INVALID;
					end
				end
				jsv_pkg::PH_EXP_BEG: begin
					if (cls == jsv_pkg::CL_PLUS || cls == jsv_pkg::CL_MINUS) begin
						phase_d = jsv_pkg::PH_EXP_SIGN;
					end else if (is_digit) begin
						phase_d = jsv_pkg::PH_EXP_DIGS;
					end else begin
						phase_d = jsv_pkg::PH_ERROR;
						err_d   = jsv_pkg::ST_INVALID;
					end
				end
				jsv_pkg::PH_EXP_DIGS: begin
					if (is_digit) begin
						phase_d = phase_q;
					end else if (cls == jsv_pkg::CL_SPACE) begin
						phase_d = jsv_pkg::PH_TRAIL;
					end else begin
						phase_d = jsv_pkg::PH_ERROR;
						err_d   = jsv_pkg::ST_NOT_SINGLE;
					end
				end
				jsv_pkg::PH_TRAIL: begin
					if (cls != jsv_pkg::CL_SPACE) begin
						phase_d = jsv_pkg::PH_ERROR;
						err_d   = jsv_pkg::ST_NOT_SINGLE;
					end
				end
				jsv_pkg::PH_ERROR: ;
				default: begin
					phase_d = jsv_pkg::PH_ERROR;
					err_d   = jsv_pkg::ST_INVALID;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		res_push   = cls_take && (cls == jsv_pkg::CL_END);
		res_status = jsv_pkg::ST_INVALID;
		res_kind   = jsv_pkg::KIND_NULL;
		case (phase_q)
			jsv_pkg::PH_LEAD: res_status = jsv_pkg::ST_EXPECT;
			jsv_pkg::PH_INT_ZERO, jsv_pkg::PH_INT_DIGS,
			jsv_pkg::PH_FRAC_DIGS, jsv_pkg::PH_EXP_DIGS: begin
				res_status = jsv_pkg::ST_OK;
				res_kind   = jsv_pkg::KIND_NUMBER;
			end
			jsv_pkg::PH_TRAIL: begin
				res_status = jsv_pkg::ST_OK;
				res_kind   = kind_q;
			end
			jsv_pkg::PH_ERROR: res_status = err_q;
			default: res_status = jsv_pkg::ST_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsv_pkg::PH_LEAD;
			kind_q  <= jsv_pkg::KIND_NULL;
			pos_q   <= '0;
			err_q   <= jsv_pkg::ST_OK;
		end else if (cls_take) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			pos_q   <= pos_d;
			err_q   <= err_d;
		end
	end

	jsv_fifo #(
		.WIDTH (jsv_pkg::RESULT_W),
		.DEPTH (RDEPTH)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data ({res_status, res_kind}),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign parse_status = res_rd[jsv_pkg::RESULT_W-1:jsv_pkg::KIND_W];
	assign value_kind   = res_rd[jsv_pkg::KIND_W-1:0];

endmodule

// File: design/json_scalar_validator.sv
// ----------------------------------------------------------------------------
// json_scalar_validator
// Checks that a zero-terminated JSON text holds one null, true, false or number.
// ----------------------------------------------------------------------------
// Text bytes are pushed one per cycle while full is low; a zero byte ends a
// text and yields one result (status and value type) on the result queue, the
// other bytes yield none. Each byte passes the class queue and one step of the
// grammar state machine, which queues an end byte's result; the block sustains
// one byte per cycle while the result queue has room. The class queue lets the
// input keep going while results wait to be popped; when the result queue is
// full the state machine holds at the end byte and the class queue fills.
module json_scalar_validator #(
	parameter int unsigned CLASS_QUEUE_DEPTH  = jsv_pkg::CLASS_QUEUE_DEPTH,
	parameter int unsigned RESULT_QUEUE_DEPTH = jsv_pkg::RESULT_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [jsv_pkg::BYTE_W-1:0]    text_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [jsv_pkg::STATUS_W-1:0]  parse_status,
	output logic [jsv_pkg::KIND_W-1:0]    value_kind
);

	logic            cls_valid;
	logic            cls_take;
	jsv_pkg::class_t cls;

	jsv_front #(
		.QDEPTH (CLASS_QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_take  (cls_take)
	);

	jsv_back #(
		.RDEPTH (RESULT_QUEUE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cls_valid    (cls_valid),
		.cls          (cls),
		.cls_take     (cls_take),
		.empty        (empty),
		.pop          (pop),
		.parse_status (parse_status),
		.value_kind   (value_kind)
	);

endmodule

// File: design/jsv_checker.sv
// ----------------------------------------------------------------------------
// jsv_checker
// Port-level checks of the JSON scalar validator, bound to the top level.
// ----------------------------------------------------------------------------
module jsv_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic [jsv_pkg::BYTE_W-1:0]    text_byte,
	input logic                          empty,
	input logic                          pop,
	input logic [jsv_pkg::STATUS_W-1:0]  parse_status,
	input logic [jsv_pkg::KIND_W-1:0]    value_kind
);

	logic end_seen_q;

	// an end byte has been transferred since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_seen_q <= 1'b0;
		end else if (push && !full && text_byte == '0) begin
			end_seen_q <= 1'b1;
		end
	end

	// queues are clear after a reset edge
	a_reset_clear: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queues not clear in reset");

	// an error result never carries a value type
	a_error_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && parse_status != jsv_pkg::ST_OK) |-> value_kind == jsv_pkg::KIND_NULL)
		else $error("error result with a value type");

	// a result needs an end byte transferred before it
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> end_seen_q)
		else $error("result without a text end");

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(parse_status) && $stable(value_kind)))
		else $error("waiting result changed");

endmodule

bind json_scalar_validator jsv_checker u_jsv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.text_byte    (text_byte),
	.empty        (empty),
	.pop          (pop),
	.parse_status (parse_status),
	.value_kind   (value_kind)
);
